>>> rtl/mac_ssid_dedupe_filter_unit_assert.svh
// Assertion macros shared by the dedupe filter checker
`ifndef MAC_SSID_DEDUPE_FILTER_UNIT_ASSERT_SVH
`define MAC_SSID_DEDUPE_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define MDSF_AST_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mdsf assertion failed");

// next-cycle implication, skipped while reset is high
`define MDSF_AST_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mdsf assertion failed");

`endif

>>> rtl/mdsf_pkg.sv
// Types and constants of the MAC and SSID dedupe filter
`default_nettype none
package mdsf_pkg;

   localparam int unsigned MAC_W   = 48;
   localparam int unsigned WORD_W  = 64;
   localparam int unsigned STAMP_W = 32;
   localparam logic [STAMP_W-1:0] COOLDOWN_RESET = 32'd8000;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic [WORD_W-1:0] w2;
      logic [WORD_W-1:0] w3;
   } key_type;

   typedef struct packed {
      key_type            key;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic hit;
      logic in_window;
   } cmp_res_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

endpackage
`default_nettype wire

>>> rtl/mac_ssid_dedupe_filter_unit.sv
// Top level of the MAC and SSID dedupe filter: sequencer, table and output register
//
// Usage:
//   req_* carries one sighting per word (MAC, four SSID words, ms time); the
//   block raises req_stall while it works on one. rsp_* returns one word per
//   sighting, rsp_suppress high for a repeat inside the cooldown window.
//   csr_* writes the cooldown in ms; csr_ready is high only while idle.
// Timing:
//   The table is walked slot by slot in index order through one comparator
//   fed by a RAM with registered read, one slot per cycle. A hit ends the
//   scan at its slot, a miss after the last slot; the result then waits in
//   S_DONE for the output register, and no new sighting is taken until the
//   block is back in S_IDLE.
// Reset:
//   Synchronous, active high. Per-slot valid bits clear at once, so every
//   slot reads as all zero; no clearing pass. Cooldown returns to 8000 ms.
// Stall:
//   A result sits in the output register; the next sighting is taken and
//   scanned meanwhile, and its result waits until the register is freed.
`default_nettype none
module mac_ssid_dedupe_filter_unit
   import mdsf_pkg::*;
#(
   parameter int unsigned SLOTS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [MAC_W-1:0]   req_mac_addr,
   input  wire logic [WORD_W-1:0]  req_ssid_word0,
   input  wire logic [WORD_W-1:0]  req_ssid_word1,
   input  wire logic [WORD_W-1:0]  req_ssid_word2,
   input  wire logic [WORD_W-1:0]  req_ssid_word3,
   input  wire logic [STAMP_W-1:0] req_now_ms,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_suppress,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [STAMP_W-1:0] csr_cooldown_ms
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]   rep_ptr_ff, rep_ptr_in;
   logic [SLOTS-1:0]   vld_ff, vld_in;
   logic [STAMP_W-1:0] cooldown_ff, cooldown_in;
   key_type            key_ff, key_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   logic               res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_suppress_ff, rsp_suppress_in;

   logic               req_take;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          cur;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   cmp_res_type        cmp_res;
   logic               out_free;

   assign req_stall    = (state_ff != S_IDLE);
   assign csr_ready    = (state_ff == S_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_suppress = rsp_suppress_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign rd_en    = (state_ff == S_SCAN) && (rd_idx_ff < CNT_W'(SLOTS));
   assign rd_addr  = rd_idx_ff[IDX_W-1:0];
   assign cur      = vld_ff[chk_idx_ff] ? entry_type'(rd_data) : '0;
   assign wr_entry = '{key: key_ff, stamp: now_ff};

   mdsf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mdsf_cmp u_cmp (
      .key_a       (key_ff),
      .key_b       (cur.key),
      .now_ms      (now_ff),
      .stamp       (cur.stamp),
      .cooldown_ms (cooldown_ff),
      .res         (cmp_res)
   );

   always_comb begin
      state_in        = state_ff;
      rd_idx_in       = rd_idx_ff;
      chk_vld_in      = chk_vld_ff;
      chk_idx_in      = chk_idx_ff;
      rep_ptr_in      = rep_ptr_ff;
      vld_in          = vld_ff;
      cooldown_in     = cooldown_ff;
      key_in          = key_ff;
      now_in          = now_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_suppress_in = rsp_suppress_ff;
      wr_en           = 1'b0;
      wr_addr         = chk_idx_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               cooldown_in = csr_cooldown_ms;
            end
            if (req_take) begin
               key_in     = '{mac: req_mac_addr, w0: req_ssid_word0, w1: req_ssid_word1,
                              w2: req_ssid_word2, w3: req_ssid_word3};
               now_in     = req_now_ms;
               rd_idx_in  = '0;
               chk_vld_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            chk_vld_in = rd_en;
            chk_idx_in = rd_addr;
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (chk_vld_ff && cmp_res.hit) begin
               res_in = cmp_res.in_window;
               if (!cmp_res.in_window) begin
                  wr_en                = 1'b1;
                  wr_addr              = chk_idx_ff;
                  vld_in[chk_idx_ff]   = 1'b1;
               end
               state_in = S_DONE;
            end else if (chk_vld_ff && (chk_idx_ff == IDX_W'(SLOTS - 1))) begin
               res_in             = 1'b0;
               wr_en              = 1'b1;
               wr_addr            = rep_ptr_ff;
               vld_in[rep_ptr_ff] = 1'b1;
               rep_ptr_in         = (rep_ptr_ff == IDX_W'(SLOTS - 1)) ? '0
                                                                      : rep_ptr_ff + IDX_W'(1);
               state_in           = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_suppress_in = res_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_idx_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         chk_idx_ff   <= '0;
         rep_ptr_ff   <= '0;
         vld_ff       <= '0;
         cooldown_ff  <= COOLDOWN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         chk_vld_ff   <= chk_vld_in;
         chk_idx_ff   <= chk_idx_in;
         rep_ptr_ff   <= rep_ptr_in;
         vld_ff       <= vld_in;
         cooldown_ff  <= cooldown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      now_ff          <= now_in;
      res_ff          <= res_in;
      rsp_suppress_ff <= rsp_suppress_in;
   end

endmodule
`default_nettype wire

>>> rtl/mdsf_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module mdsf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/mdsf_cmp.sv
// Shared slot comparator: key equality and cooldown age check
`default_nettype none
module mdsf_cmp
   import mdsf_pkg::*;
(
   input  wire key_type            key_a,
   input  wire key_type            key_b,
   input  wire logic [STAMP_W-1:0] now_ms,
   input  wire logic [STAMP_W-1:0] stamp,
   input  wire logic [STAMP_W-1:0] cooldown_ms,
   output cmp_res_type             res
);

   logic [STAMP_W-1:0] age;

   assign age           = now_ms - stamp;
   assign res.hit       = (key_a == key_b);
   assign res.in_window = (age < cooldown_ms);

endmodule
`default_nettype wire

>>> rtl/mdsf_chk.sv
// Port-level checker for the dedupe filter, bound to the top level
`default_nettype none
`include "mac_ssid_dedupe_filter_unit_assert.svh"
module mdsf_chk (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_suppress,
   input wire logic csr_ready
);

   // hold a stalled result word
   `MDSF_AST_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_suppress))
   // busy after taking a word
   `MDSF_AST_NXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   // no register writes while a sighting is in flight
   `MDSF_AST_IMP(a_csr_idle_only, clock, reset, req_stall, !csr_ready)
   // no result straight out of reset
   `MDSF_AST_IMP(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind mac_ssid_dedupe_filter_unit mdsf_chk u_mdsf_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_suppress (rsp_suppress),
   .csr_ready    (csr_ready)
);
`default_nettype wire
